[hw/rtl/sd_card_command_state_machine_core_macros.svh]
// ----------------------------------------------------------------------------
// SD card command core assertion macros
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef SD_CARD_COMMAND_STATE_MACHINE_CORE_MACROS_SVH
`define SD_CARD_COMMAND_STATE_MACHINE_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SDC_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SDC_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked while reset is applied.
`define SDC_ASSERT_RAW(name, clk, ante, cons, msg) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/sdc_pkg.sv]
// ----------------------------------------------------------------------------
// SD card command core package
// Types, state codes, command indexes and status bit masks of the core.
// ----------------------------------------------------------------------------
`default_nettype none

package sdc_pkg;

  // Card geometry.
  localparam logic [32:0] CARD_BYTES     = 33'd4194304;
  localparam int          MAX_BLOCK_LOG2 = 9;
  localparam int          BLK_LEN_W      = MAX_BLOCK_LOG2 + 1;
  localparam logic [32:0] MAX_BLOCK_LEN  = 33'd1 << MAX_BLOCK_LOG2;

  // Item kinds.
  localparam logic [1:0] KIND_CMD   = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;
  localparam logic [1:0] KIND_NONE  = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_CID_HIGH = 2'd0;
  localparam logic [1:0] REG_CID_LOW  = 2'd1;
  localparam logic [1:0] REG_CSD_HIGH = 2'd2;
  localparam logic [1:0] REG_CSD_LOW  = 2'd3;

  // Card states.
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_READY = 4'd1;
  localparam logic [3:0] ST_IDENT = 4'd2;
  localparam logic [3:0] ST_STBY  = 4'd3;
  localparam logic [3:0] ST_TRAN  = 4'd4;
  localparam logic [3:0] ST_DATA  = 4'd5;
  localparam logic [3:0] ST_RCV   = 4'd6;
  localparam logic [3:0] ST_PRG   = 4'd7;
  localparam logic [3:0] ST_DIS   = 4'd8;

  // Command indexes.
  localparam logic [5:0] IDX_GO_IDLE         = 6'd0;
  localparam logic [5:0] IDX_SEND_OP_COND    = 6'd1;
  localparam logic [5:0] IDX_ALL_SEND_CID    = 6'd2;
  localparam logic [5:0] IDX_SEND_RCA        = 6'd3;
  localparam logic [5:0] IDX_SET_DSR         = 6'd4;
  localparam logic [5:0] IDX_SWITCH          = 6'd6;
  localparam logic [5:0] IDX_SELECT          = 6'd7;
  localparam logic [5:0] IDX_SEND_IF_COND    = 6'd8;
  localparam logic [5:0] IDX_SEND_CSD        = 6'd9;
  localparam logic [5:0] IDX_SEND_CID        = 6'd10;
  localparam logic [5:0] IDX_STOP            = 6'd12;
  localparam logic [5:0] IDX_SEND_STATUS     = 6'd13;
  localparam logic [5:0] IDX_GO_INACTIVE     = 6'd15;
  localparam logic [5:0] IDX_SET_BLOCKLEN    = 6'd16;
  localparam logic [5:0] IDX_READ_SINGLE     = 6'd17;
  localparam logic [5:0] IDX_READ_MULTI      = 6'd18;
  localparam logic [5:0] IDX_SET_BLOCK_COUNT = 6'd23;
  localparam logic [5:0] IDX_WRITE_SINGLE    = 6'd24;
  localparam logic [5:0] IDX_WRITE_MULTI     = 6'd25;
  localparam logic [5:0] IDX_APP_OP_COND     = 6'd41;
  localparam logic [5:0] IDX_SEND_SCR        = 6'd51;
  localparam logic [5:0] IDX_APP_CMD         = 6'd55;

  // Status word masks.
  localparam logic [31:0] CLR_ON_READ  = 32'hfd39a028;
  localparam logic [31:0] R6_FIELDS    = 32'h00c81fff;
  localparam logic [31:0] R6_CLEAR     = CLR_ON_READ & R6_FIELDS;
  localparam logic [31:0] OCR_VALUE    = 32'h80ffff00;
  localparam logic [31:0] STATUS_RESET = 32'h00000100;
  localparam logic [31:0] STATE_KEEP   = 32'hffffe1ff;
  localparam logic [31:0] BIT_ADDR_ERR = 32'h40000000;
  localparam logic [31:0] BIT_BLEN_ERR = 32'h20000000;
  localparam logic [31:0] BIT_ILLEGAL  = 32'h00400000;
  localparam logic [31:0] BIT_APP      = 32'h00000020;

  typedef struct packed {
    logic [1:0]  command;
    logic [5:0]  cmd_index;
    logic [31:0] cmd_argument;
    logic [10:0] block_count;
    logic [10:0] block_size;
  } in_item_t;

  typedef struct packed {
    logic [31:0] resp_word0;
    logic [31:0] resp_word1;
    logic [31:0] resp_word2;
    logic [31:0] resp_word3;
    logic        xfer_accepted;
    logic [10:0] xfer_blocks;
    logic [10:0] xfer_block_size;
    logic [31:0] xfer_address;
  } out_item_t;

  typedef struct packed {
    logic [63:0] cid_high;
    logic [63:0] cid_low;
    logic [63:0] csd_high;
    logic [63:0] csd_low;
  } card_regs_t;

endpackage

`default_nettype wire

[hw/rtl/sdc_in_if.sv]
// ----------------------------------------------------------------------------
// SD card command core input channel
// Valid/ready channel carrying one command or transfer request.
// ----------------------------------------------------------------------------
`default_nettype none

interface sdc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [5:0]  cmd_index;
  logic [31:0] cmd_argument;
  logic [10:0] block_count;
  logic [10:0] block_size;

  modport source (
    output valid, command, cmd_index, cmd_argument, block_count, block_size,
    input  ready
  );
  modport sink (
    input  valid, command, cmd_index, cmd_argument, block_count, block_size,
    output ready
  );
endinterface

`default_nettype wire

[hw/rtl/sdc_out_if.sv]
// ----------------------------------------------------------------------------
// SD card command core result channel
// Valid/ready channel carrying one response or transfer grant.
// ----------------------------------------------------------------------------
`default_nettype none

interface sdc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] resp_word0;
  logic [31:0] resp_word1;
  logic [31:0] resp_word2;
  logic [31:0] resp_word3;
  logic        xfer_accepted;
  logic [10:0] xfer_blocks;
  logic [10:0] xfer_block_size;
  logic [31:0] xfer_address;

  modport source (
    output valid, resp_word0, resp_word1, resp_word2, resp_word3,
           xfer_accepted, xfer_blocks, xfer_block_size, xfer_address,
    input  ready
  );
  modport sink (
    input  valid, resp_word0, resp_word1, resp_word2, resp_word3,
           xfer_accepted, xfer_blocks, xfer_block_size, xfer_address,
    output ready
  );
  modport monitor (
    input valid, ready, resp_word0, resp_word1, resp_word2, resp_word3,
          xfer_accepted, xfer_blocks, xfer_block_size, xfer_address
  );
endinterface

`default_nettype wire

[hw/rtl/sdc_cfg_if.sv]
// ----------------------------------------------------------------------------
// SD card command core configuration channel
// Valid/ready write channel carrying a register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface sdc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reg_index;
  logic [63:0] wr_data;

  modport source (output valid, reg_index, wr_data, input ready);
  modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

`default_nettype wire

[hw/rtl/sdc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// SD card command core configuration registers
// Holds the CID and CSD contents returned by R2 responses.
// ----------------------------------------------------------------------------
`default_nettype none

module sdc_cfg_regs (
  input  wire              clk,
  input  wire              rst_n,
  sdc_cfg_if.sink          cfg_chan,
  output sdc_pkg::card_regs_t regs
);

  sdc_pkg::card_regs_t regs_r;
  sdc_pkg::card_regs_t regs_nxt;

  assign cfg_chan.ready = 1'b1;
  assign regs           = regs_r;

  always_comb begin
    regs_nxt = regs_r;
    if (cfg_chan.valid) begin
      case (cfg_chan.reg_index)
        sdc_pkg::REG_CID_HIGH: regs_nxt.cid_high = cfg_chan.wr_data;
        sdc_pkg::REG_CID_LOW:  regs_nxt.cid_low  = cfg_chan.wr_data;
        sdc_pkg::REG_CSD_HIGH: regs_nxt.csd_high = cfg_chan.wr_data;
        sdc_pkg::REG_CSD_LOW:  regs_nxt.csd_low  = cfg_chan.wr_data;
        default: regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= '0;
    end else begin
      regs_r <= regs_nxt;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/sdc_in_stage.sv]
// ----------------------------------------------------------------------------
// SD card command core input register
// Captures one transaction and holds it until the engine consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module sdc_in_stage (
  input  wire               clk,
  input  wire               rst_n,
  sdc_in_if.sink            in_chan,
  input  wire               take,
  output logic              item_valid,
  output sdc_pkg::in_item_t item
);

  logic              vld_r;
  logic              vld_nxt;
  sdc_pkg::in_item_t item_r;
  logic              load;

  assign in_chan.ready = !vld_r || take;
  assign load          = in_chan.valid && in_chan.ready;
  assign item_valid    = vld_r;
  assign item          = item_r;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (take) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= '{command:      in_chan.command,
                  cmd_index:    in_chan.cmd_index,
                  cmd_argument: in_chan.cmd_argument,
                  block_count:  in_chan.block_count,
                  block_size:   in_chan.block_size};
    end
  end

endmodule

`default_nettype wire

[hw/rtl/sdc_engine.sv]
// ----------------------------------------------------------------------------
// SD card command core engine
// Card state, status word and transfer bookkeeping; forms one result per command or transfer item.
// ----------------------------------------------------------------------------
`default_nettype none

module sdc_engine (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 fire,
  input  sdc_pkg::in_item_t   item,
  input  sdc_pkg::card_regs_t regs,
  output logic                res_valid,
  output sdc_pkg::out_item_t  res
);

  localparam int BW = sdc_pkg::BLK_LEN_W;

  logic [3:0]    card_state_r, card_state_nxt;
  logic [31:0]   status_r,     status_nxt;
  logic [15:0]   rca_r,        rca_nxt;
  logic [31:0]   ifc_r,        ifc_nxt;
  logic          app_r,        app_nxt;
  logic [5:0]    last_cmd_r,   last_cmd_nxt;
  logic [BW-1:0] blk_len_r,    blk_len_nxt;
  logic [31:0]   offset_r,     offset_nxt;

  logic [31:0]   st_run;
  logic [31:0]   st_ref;
  logic [32:0]   addr_end;
  logic          addr_bad;
  logic [21:0]   xfer_bytes;
  logic          in_place;
  logic          cmd_ok;

  assign addr_end   = {1'b0, item.cmd_argument} + 33'(blk_len_r);
  assign addr_bad   = addr_end > sdc_pkg::CARD_BYTES;
  assign xfer_bytes = 22'(item.block_count) * 22'(item.block_size);

  always_comb begin
    card_state_nxt = card_state_r;
    status_nxt     = status_r;
    rca_nxt        = rca_r;
    ifc_nxt        = ifc_r;
    app_nxt        = app_r;
    last_cmd_nxt   = last_cmd_r;
    blk_len_nxt    = blk_len_r;
    offset_nxt     = offset_r;
    st_run         = status_r;
    st_ref         = status_r;
    in_place       = 1'b0;
    cmd_ok         = 1'b0;
    res_valid      = 1'b0;
    res            = '0;

    case (item.command)
      sdc_pkg::KIND_CMD: begin
        res_valid    = fire;
        last_cmd_nxt = item.cmd_index;
        if (app_r) begin
          // Application command: only a few indexes are defined.
          app_nxt    = 1'b0;
          offset_nxt = '0;
          case (item.cmd_index)
            sdc_pkg::IDX_SWITCH: ;
            sdc_pkg::IDX_APP_OP_COND: card_state_nxt = sdc_pkg::ST_READY;
            sdc_pkg::IDX_SEND_STATUS, sdc_pkg::IDX_SEND_SCR:
              card_state_nxt = sdc_pkg::ST_DATA;
            default: st_run = st_run | sdc_pkg::BIT_ILLEGAL;
          endcase
        end else begin
          st_run = st_run & ~sdc_pkg::BIT_APP;
          case (item.cmd_index)
            sdc_pkg::IDX_GO_IDLE: begin
              card_state_nxt = sdc_pkg::ST_IDLE;
              rca_nxt        = '0;
              st_run         = sdc_pkg::STATUS_RESET;
            end
            sdc_pkg::IDX_SEND_OP_COND: card_state_nxt = sdc_pkg::ST_TRAN;
            sdc_pkg::IDX_ALL_SEND_CID: card_state_nxt = sdc_pkg::ST_IDENT;
            sdc_pkg::IDX_SEND_RCA: begin
              card_state_nxt = sdc_pkg::ST_STBY;
              rca_nxt        = rca_r + 16'd1;
            end
            sdc_pkg::IDX_SET_DSR, sdc_pkg::IDX_SEND_STATUS: ;
            sdc_pkg::IDX_SWITCH: card_state_nxt = sdc_pkg::ST_READY;
            sdc_pkg::IDX_SELECT: begin
              case (card_state_r)
                sdc_pkg::ST_STBY: card_state_nxt = sdc_pkg::ST_TRAN;
                sdc_pkg::ST_TRAN: card_state_nxt = sdc_pkg::ST_STBY;
                sdc_pkg::ST_PRG:  card_state_nxt = sdc_pkg::ST_DIS;
                sdc_pkg::ST_DIS:  card_state_nxt = sdc_pkg::ST_PRG;
                default:          card_state_nxt = card_state_r;
              endcase
            end
            sdc_pkg::IDX_SEND_IF_COND: ifc_nxt = item.cmd_argument;
            sdc_pkg::IDX_SEND_CSD, sdc_pkg::IDX_SEND_CID:
              card_state_nxt = sdc_pkg::ST_STBY;
            sdc_pkg::IDX_STOP: begin
              card_state_nxt = sdc_pkg::ST_TRAN;
              offset_nxt     = '0;
            end
            sdc_pkg::IDX_GO_INACTIVE: card_state_nxt = sdc_pkg::ST_IDLE;
            sdc_pkg::IDX_SET_BLOCKLEN: begin
              if ({1'b0, item.cmd_argument} > sdc_pkg::MAX_BLOCK_LEN) begin
                st_run = st_run | sdc_pkg::BIT_BLEN_ERR;
              end else begin
                blk_len_nxt = item.cmd_argument[BW-1:0];
              end
            end
            sdc_pkg::IDX_READ_SINGLE, sdc_pkg::IDX_READ_MULTI: begin
              card_state_nxt = sdc_pkg::ST_DATA;
              offset_nxt     = item.cmd_argument;
              if (addr_bad) st_run = st_run | sdc_pkg::BIT_ADDR_ERR;
            end
            sdc_pkg::IDX_SET_BLOCK_COUNT: ;
            sdc_pkg::IDX_WRITE_SINGLE, sdc_pkg::IDX_WRITE_MULTI: begin
              card_state_nxt = sdc_pkg::ST_RCV;
              offset_nxt     = item.cmd_argument;
              if (addr_bad) st_run = st_run | sdc_pkg::BIT_ADDR_ERR;
            end
            sdc_pkg::IDX_APP_CMD: begin
              st_run  = st_run | sdc_pkg::BIT_APP;
              app_nxt = 1'b1;
            end
            default: st_run = st_run | sdc_pkg::BIT_ILLEGAL;
          endcase
        end

        // Response: an illegal command answers with all-zero words and only drops
        // the illegal flag; otherwise the current state is folded in first.
        if ((st_run & sdc_pkg::BIT_ILLEGAL) != '0) begin
          status_nxt = st_run & ~sdc_pkg::BIT_ILLEGAL;
        end else begin
          st_ref     = (st_run & sdc_pkg::STATE_KEEP) | {19'd0, card_state_nxt, 9'd0};
          status_nxt = st_ref;
          case (item.cmd_index)
            sdc_pkg::IDX_GO_IDLE, sdc_pkg::IDX_SET_DSR: ;
            sdc_pkg::IDX_ALL_SEND_CID, sdc_pkg::IDX_SEND_CID: begin
              res.resp_word0 = regs.cid_high[63:32];
              res.resp_word1 = regs.cid_high[31:0];
              res.resp_word2 = regs.cid_low[63:32];
              res.resp_word3 = regs.cid_low[31:0];
            end
            sdc_pkg::IDX_SEND_CSD: begin
              res.resp_word0 = regs.csd_high[63:32];
              res.resp_word1 = regs.csd_high[31:0];
              res.resp_word2 = regs.csd_low[63:32];
              res.resp_word3 = regs.csd_low[31:0];
            end
            sdc_pkg::IDX_SEND_OP_COND, sdc_pkg::IDX_APP_OP_COND:
              res.resp_word0 = sdc_pkg::OCR_VALUE;
            sdc_pkg::IDX_SEND_RCA: begin
              res.resp_word0 = {rca_nxt, st_ref[23:22], st_ref[19], st_ref[12:0]};
              status_nxt     = st_ref & ~sdc_pkg::R6_CLEAR;
            end
            sdc_pkg::IDX_SEND_IF_COND: res.resp_word0 = ifc_nxt;
            default: begin
              res.resp_word0 = st_ref;
              status_nxt     = st_ref & ~sdc_pkg::CLR_ON_READ;
            end
          endcase
        end
      end

      sdc_pkg::KIND_READ, sdc_pkg::KIND_WRITE: begin
        res_valid = fire;
        if (item.command == sdc_pkg::KIND_READ) begin
          in_place = card_state_r == sdc_pkg::ST_DATA;
          cmd_ok   = last_cmd_r == sdc_pkg::IDX_SEND_SCR ||
                     last_cmd_r == sdc_pkg::IDX_SEND_STATUS ||
                     last_cmd_r == sdc_pkg::IDX_READ_SINGLE ||
                     last_cmd_r == sdc_pkg::IDX_READ_MULTI;
        end else begin
          in_place = card_state_r == sdc_pkg::ST_RCV;
          cmd_ok   = last_cmd_r == sdc_pkg::IDX_WRITE_SINGLE ||
                     last_cmd_r == sdc_pkg::IDX_WRITE_MULTI;
        end
        // The offset advances whenever the card is in the transfer state,
        // even if the preceding command does not allow the transfer.
        if (in_place) begin
          offset_nxt = offset_r + 32'(xfer_bytes);
        end
        if (in_place && cmd_ok) begin
          res.xfer_accepted   = 1'b1;
          res.xfer_blocks     = item.block_count;
          res.xfer_block_size = item.block_size;
          res.xfer_address    = offset_r;
        end else begin
          card_state_nxt = sdc_pkg::ST_TRAN;
        end
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      card_state_r <= sdc_pkg::ST_IDLE;
      status_r     <= sdc_pkg::STATUS_RESET;
      rca_r        <= '0;
      ifc_r        <= '0;
      app_r        <= 1'b0;
      last_cmd_r   <= '0;
      blk_len_r    <= '0;
      offset_r     <= '0;
    end else if (fire) begin
      card_state_r <= card_state_nxt;
      status_r     <= status_nxt;
      rca_r        <= rca_nxt;
      ifc_r        <= ifc_nxt;
      app_r        <= app_nxt;
      last_cmd_r   <= last_cmd_nxt;
      blk_len_r    <= blk_len_nxt;
      offset_r     <= offset_nxt;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/sdc_out_stage.sv]
// ----------------------------------------------------------------------------
// SD card command core result register
// Holds one result transaction until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module sdc_out_stage (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                res_valid,
  input  sdc_pkg::out_item_t res,
  output logic               stage_free,
  sdc_out_if.source          out_chan
);

  logic               vld_r;
  logic               vld_nxt;
  sdc_pkg::out_item_t res_r;

  assign stage_free = !vld_r || out_chan.ready;

  always_comb begin
    vld_nxt = vld_r && !out_chan.ready;
    if (res_valid) begin
      vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      res_r <= res;
    end
  end

  assign out_chan.valid           = vld_r;
  assign out_chan.resp_word0      = res_r.resp_word0;
  assign out_chan.resp_word1      = res_r.resp_word1;
  assign out_chan.resp_word2      = res_r.resp_word2;
  assign out_chan.resp_word3      = res_r.resp_word3;
  assign out_chan.xfer_accepted   = res_r.xfer_accepted;
  assign out_chan.xfer_blocks     = res_r.xfer_blocks;
  assign out_chan.xfer_block_size = res_r.xfer_block_size;
  assign out_chan.xfer_address    = res_r.xfer_address;

endmodule

`default_nettype wire

[hw/rtl/sd_card_command_state_machine_core.sv]
// ----------------------------------------------------------------------------
// SD card command state machine core
// Card side of the SD command interface: commands in, responses out.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one transaction per item: a card command (index and
//   argument) or a read or write transfer request (block count and size).
//   out_chan returns one result per item: R1/R2/R3/R6/R7 response words for
//   a command, or the grant (geometry and start offset) of a transfer.
//   Items of kind 3 are consumed and give no result.
//   cfg_chan writes the CID and CSD registers and is always ready; the user
//   writes it only while no item is in flight, which the core does not enforce.
//   A transaction accepted on in_chan is registered in the input register,
//   passes through the engine into the result register, and is shown on
//   out_chan from there.
//   Throughput: one item per cycle while results are taken; the card state
//   update is one pass of logic between the input and result registers.
//   Reset puts the card in idle with the status word at ready for data, and
//   clears the address, the transfer offset and the CID/CSD contents.
//   When the receiver stalls, the result register holds, the input register
//   fills, and in_chan.ready drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module sd_card_command_state_machine_core (
  input  wire       clk,
  input  wire       rst_n,
  sdc_in_if.sink    in_chan,
  sdc_out_if.source out_chan,
  sdc_cfg_if.sink   cfg_chan
);

  sdc_pkg::card_regs_t regs;
  sdc_pkg::in_item_t   item;
  sdc_pkg::out_item_t  res;
  logic                item_valid;
  logic                stage_free;
  logic                fire;
  logic                res_valid;

  assign fire = item_valid && stage_free;

  sdc_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .regs     (regs)
  );

  sdc_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .take       (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  sdc_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .item      (item),
    .regs      (regs),
    .res_valid (res_valid),
    .res       (res)
  );

  sdc_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res        (res),
    .stage_free (stage_free),
    .out_chan   (out_chan)
  );

endmodule

`default_nettype wire

[hw/rtl/sdc_checker.sv]
// ----------------------------------------------------------------------------
// SD card command core checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sd_card_command_state_machine_core_macros.svh"

module sdc_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        out_valid,
  input wire        out_ready,
  input wire [31:0] out_resp_word0,
  input wire [31:0] out_resp_word1,
  input wire [31:0] out_resp_word2,
  input wire [31:0] out_resp_word3,
  input wire        out_xfer_accepted,
  input wire [10:0] out_xfer_blocks,
  input wire [10:0] out_xfer_block_size,
  input wire [31:0] out_xfer_address
);

  // A stalled result stays offered with the same first response word and transfer address.
  `SDC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_resp_word0) && $stable(out_xfer_address), "stalled result changed")

  // Nothing is offered in the cycle after reset.
  `SDC_ASSERT_RAW(a_reset_empty, clk, !rst_n, !out_valid, "result valid after reset")

  // A transfer grant carries no response words.
  `SDC_ASSERT_SAME(a_grant_no_resp, clk, rst_n, out_valid && out_xfer_accepted, out_resp_word0 == '0 && out_resp_word1 == '0 && out_resp_word2 == '0 && out_resp_word3 == '0, "transfer grant with response words")

  // Without a grant, the transfer fields are all zero.
  `SDC_ASSERT_SAME(a_no_grant_zero, clk, rst_n, out_valid && !out_xfer_accepted, out_xfer_blocks == '0 && out_xfer_block_size == '0 && out_xfer_address == '0, "transfer fields without grant")

endmodule

bind sd_card_command_state_machine_core sdc_checker u_sdc_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_chan.valid),
  .out_ready           (out_chan.ready),
  .out_resp_word0      (out_chan.resp_word0),
  .out_resp_word1      (out_chan.resp_word1),
  .out_resp_word2      (out_chan.resp_word2),
  .out_resp_word3      (out_chan.resp_word3),
  .out_xfer_accepted   (out_chan.xfer_accepted),
  .out_xfer_blocks     (out_chan.xfer_blocks),
  .out_xfer_block_size (out_chan.xfer_block_size),
  .out_xfer_address    (out_chan.xfer_address)
);

`default_nettype wire

[dv/tb.sv]
// ----------------------------------------------------------------------------
// SD card command state machine core testbench
// Sends card commands and transfer requests through the valid/ready channels,
// predicts every response and transfer grant in step with the card state and
// compares each result field by field against that prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import sdc_pkg::*;

  logic clk;
  logic rst_n;

  sdc_in_if  in_chan ();
  sdc_out_if out_chan ();
  sdc_cfg_if cfg_chan ();

  sd_card_command_state_machine_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  // Card model state, kept in step with every accepted transaction.
  logic [3:0]  crd_state;
  logic [31:0] model_status;
  logic [15:0] card_rca;
  logic [31:0] if_echo;
  logic        app_armed;
  logic [5:0]  prev_index;
  logic [9:0]  blk_len;
  logic [31:0] xfer_ofs;
  card_regs_t  model_regs;

  out_item_t pending_responses[$];
  int        send_idle_pct;
  int        recv_idle_pct;
  int        items_sent;
  int        results_seen;
  int        fail_count;

  logic [5:0] legal_index [22] = '{
    IDX_GO_IDLE, IDX_SEND_OP_COND, IDX_ALL_SEND_CID, IDX_SEND_RCA, IDX_SET_DSR,
    IDX_SWITCH, IDX_SELECT, IDX_SEND_IF_COND, IDX_SEND_CSD, IDX_SEND_CID,
    IDX_STOP, IDX_SEND_STATUS, IDX_GO_INACTIVE, IDX_SET_BLOCKLEN,
    IDX_READ_SINGLE, IDX_READ_MULTI, IDX_SET_BLOCK_COUNT, IDX_WRITE_SINGLE,
    IDX_WRITE_MULTI, IDX_APP_OP_COND, IDX_SEND_SCR, IDX_APP_CMD
  };

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 500000);
    $display("sd_card_command_state_machine_core test failed");
    $finish;
  end

  // Works out the result of one command or transfer and updates the card model.
  function automatic out_item_t predict_response(in_item_t it);
    out_item_t   r;
    logic [31:0] start;
    logic [3:0]  want_state;
    logic        ok;
    r = '0;
    if (it.command == KIND_CMD) begin
      prev_index = it.cmd_index;
      if (app_armed) begin
        app_armed = 1'b0;
        case (it.cmd_index)
          IDX_SWITCH: ;
          IDX_APP_OP_COND: crd_state = ST_READY;
          IDX_SEND_STATUS, IDX_SEND_SCR: crd_state = ST_DATA;
          default: model_status |= BIT_ILLEGAL;
        endcase
        xfer_ofs = '0;
      end else begin
        model_status &= ~BIT_APP;
        case (it.cmd_index)
          IDX_GO_IDLE: begin
            crd_state    = ST_IDLE;
            card_rca     = '0;
            model_status = STATUS_RESET;
          end
          IDX_SEND_OP_COND: crd_state = ST_TRAN;
          IDX_ALL_SEND_CID: crd_state = ST_IDENT;
          IDX_SEND_RCA: begin
            crd_state = ST_STBY;
            card_rca  = card_rca + 16'd1;
          end
          IDX_SET_DSR, IDX_SEND_STATUS, IDX_SET_BLOCK_COUNT: ;
          IDX_SWITCH: crd_state = ST_READY;
          IDX_SELECT: begin
            case (crd_state)
              ST_STBY: crd_state = ST_TRAN;
              ST_TRAN: crd_state = ST_STBY;
              ST_PRG:  crd_state = ST_DIS;
              ST_DIS:  crd_state = ST_PRG;
              default: ;
            endcase
          end
          IDX_SEND_IF_COND: if_echo = it.cmd_argument;
          IDX_SEND_CSD, IDX_SEND_CID: crd_state = ST_STBY;
          IDX_STOP: begin
            crd_state = ST_TRAN;
            xfer_ofs  = '0;
          end
          IDX_GO_INACTIVE: crd_state = ST_IDLE;
          IDX_SET_BLOCKLEN: begin
            if ({1'b0, it.cmd_argument} > MAX_BLOCK_LEN) model_status |= BIT_BLEN_ERR;
            else blk_len = it.cmd_argument[9:0];
          end
          IDX_READ_SINGLE, IDX_READ_MULTI, IDX_WRITE_SINGLE, IDX_WRITE_MULTI: begin
            crd_state = (it.cmd_index inside {IDX_READ_SINGLE, IDX_READ_MULTI}) ?
                        ST_DATA : ST_RCV;
            // The end of the first block is checked without wrapping.
            if ({1'b0, it.cmd_argument} + {23'b0, blk_len} > CARD_BYTES)
              model_status |= BIT_ADDR_ERR;
            xfer_ofs = it.cmd_argument;
          end
          IDX_APP_CMD: begin
            model_status |= BIT_APP;
            app_armed    = 1'b1;
          end
          default: model_status |= BIT_ILLEGAL;
        endcase
      end

      // An illegal command answers with zeros and leaves the state bits stale.
      if ((model_status & BIT_ILLEGAL) != 0) begin
        model_status &= ~BIT_ILLEGAL;
      end else begin
        model_status = (model_status & STATE_KEEP) | (32'(crd_state) << 9);
        case (it.cmd_index)
          IDX_GO_IDLE, IDX_SET_DSR: ;
          IDX_ALL_SEND_CID, IDX_SEND_CID: begin
            {r.resp_word0, r.resp_word1} = model_regs.cid_high;
            {r.resp_word2, r.resp_word3} = model_regs.cid_low;
          end
          IDX_SEND_CSD: begin
            {r.resp_word0, r.resp_word1} = model_regs.csd_high;
            {r.resp_word2, r.resp_word3} = model_regs.csd_low;
          end
          IDX_SEND_OP_COND, IDX_APP_OP_COND: r.resp_word0 = OCR_VALUE;
          IDX_SEND_RCA: begin
            r.resp_word0 = {card_rca, model_status[23:22], model_status[19],
                            model_status[12:0]};
            model_status &= ~R6_CLEAR;
          end
          IDX_SEND_IF_COND: r.resp_word0 = if_echo;
          default: begin
            r.resp_word0 = model_status;
            model_status &= ~CLR_ON_READ;
          end
        endcase
      end
    end else begin
      if (it.command == KIND_READ) begin
        want_state = ST_DATA;
        ok = prev_index inside {IDX_SEND_SCR, IDX_SEND_STATUS, IDX_READ_SINGLE,
                                IDX_READ_MULTI};
      end else begin
        want_state = ST_RCV;
        ok = prev_index inside {IDX_WRITE_SINGLE, IDX_WRITE_MULTI};
      end
      if (crd_state != want_state) begin
        crd_state = ST_TRAN;
      end else begin
        // The offset advances even when the last command rules the transfer out.
        start    = xfer_ofs;
        xfer_ofs = xfer_ofs + ({21'b0, it.block_count} * {21'b0, it.block_size});
        if (ok) begin
          r.xfer_accepted   = 1'b1;
          r.xfer_blocks     = it.block_count;
          r.xfer_block_size = it.block_size;
          r.xfer_address    = start;
        end else begin
          crd_state = ST_TRAN;
        end
      end
    end
    return r;
  endfunction

  function automatic in_item_t cmd_item(logic [5:0] idx, logic [31:0] arg);
    in_item_t it;
    it = '0;
    it.command      = KIND_CMD;
    it.cmd_index    = idx;
    it.cmd_argument = arg;
    return it;
  endfunction

  function automatic in_item_t xfer_item(logic [1:0] kind, logic [10:0] blocks,
                                         logic [10:0] size);
    in_item_t it;
    it = '0;
    it.command     = kind;
    it.block_count = blocks;
    it.block_size  = size;
    return it;
  endfunction

  function automatic logic [10:0] rand_count();
    case ($urandom_range(3))
      0: return 11'($urandom_range(8));
      1: return 11'($urandom_range(1024));
      2: return $urandom_range(1) ? 11'd1024 : 11'd0;
      default: return 11'($urandom_range(2047));
    endcase
  endfunction

  function automatic logic [31:0] rand_address();
    if ($urandom_range(5) == 0) return $urandom;
    return $urandom_range(32'(CARD_BYTES - 33'd1));
  endfunction

  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_chan.valid <= 1'b0;
    end
    @(negedge clk);
    in_chan.valid        <= 1'b1;
    in_chan.command      <= it.command;
    in_chan.cmd_index    <= it.cmd_index;
    in_chan.cmd_argument <= it.cmd_argument;
    in_chan.block_count  <= it.block_count;
    in_chan.block_size   <= it.block_size;
    do @(posedge clk); while (!in_chan.ready);
    if (it.command != KIND_NONE) begin
      pending_responses.push_back(predict_response(it));
      items_sent++;
    end
  endtask

  // Lets the core run dry, a trailing kind 3 item included.
  task automatic settle_block();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_card_reg(logic [1:0] idx, logic [63:0] value);
    @(negedge clk);
    cfg_chan.valid     <= 1'b1;
    cfg_chan.reg_index <= idx;
    cfg_chan.wr_data   <= value;
    do @(posedge clk); while (!cfg_chan.ready);
    case (idx)
      REG_CID_HIGH: model_regs.cid_high = value;
      REG_CID_LOW:  model_regs.cid_low  = value;
      REG_CSD_HIGH: model_regs.csd_high = value;
      default:      model_regs.csd_low  = value;
    endcase
    @(negedge clk);
    cfg_chan.valid <= 1'b0;
  endtask

  task automatic configure_card(logic [63:0] cid_hi, logic [63:0] cid_lo,
                                logic [63:0] csd_hi, logic [63:0] csd_lo);
    settle_block();
    write_card_reg(REG_CID_HIGH, cid_hi);
    write_card_reg(REG_CID_LOW, cid_lo);
    write_card_reg(REG_CSD_HIGH, csd_hi);
    write_card_reg(REG_CSD_LOW, csd_lo);
  endtask

  task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      if (fail_count < 10)
        $display("result %0d: %s expected %h, got %h", results_seen, name, want, got);
      fail_count++;
    end
  endtask

  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_responses.size() == 0) begin
        if (fail_count < 10)
          $display("result %0d arrived with no transaction waiting", results_seen);
        fail_count++;
      end else begin
        out_item_t want;
        want = pending_responses.pop_front();
        compare_field("resp_word0", out_chan.resp_word0, want.resp_word0);
        compare_field("resp_word1", out_chan.resp_word1, want.resp_word1);
        compare_field("resp_word2", out_chan.resp_word2, want.resp_word2);
        compare_field("resp_word3", out_chan.resp_word3, want.resp_word3);
        compare_field("xfer_accepted", 32'(out_chan.xfer_accepted),
                      32'(want.xfer_accepted));
        compare_field("xfer_blocks", 32'(out_chan.xfer_blocks), 32'(want.xfer_blocks));
        compare_field("xfer_block_size", 32'(out_chan.xfer_block_size),
                      32'(want.xfer_block_size));
        compare_field("xfer_address", out_chan.xfer_address, want.xfer_address);
      end
      results_seen++;
    end
  end

  // CID and CSD readback, first with the reset contents and then with extremes.
  task automatic test_card_registers();
    send_item(cmd_item(IDX_ALL_SEND_CID, 32'h0));
    configure_card('1, '0, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
    send_item(cmd_item(IDX_ALL_SEND_CID, 32'hffff_ffff));
    send_item(cmd_item(IDX_SEND_CID, 32'h0));
    send_item(cmd_item(IDX_SEND_CSD, 32'h0));
  endtask

  task automatic test_command_set();
    send_item(cmd_item(IDX_GO_IDLE, 32'h0));
    send_item(cmd_item(IDX_SEND_IF_COND, 32'hffff_ffff));
    send_item(cmd_item(IDX_APP_CMD, 32'h0));
    send_item(cmd_item(IDX_APP_OP_COND, 32'h4030_0000));
    send_item(cmd_item(IDX_SEND_RCA, 32'h0));
    send_item(cmd_item(IDX_SELECT, 32'h0001_0000));
    // One past the largest block length is refused and the old length stays.
    send_item(cmd_item(IDX_SET_BLOCKLEN, 32'd513));
    send_item(cmd_item(IDX_SET_BLOCKLEN, 32'd512));
    send_item(cmd_item(IDX_STOP, 32'h0));
    // Go idle is not an application command, so it is flagged as illegal.
    send_item(cmd_item(IDX_APP_CMD, 32'h0));
    send_item(cmd_item(IDX_GO_IDLE, 32'h0));
    send_item(cmd_item(6'd63, 32'h0));
    send_item(xfer_item(KIND_NONE, 11'h7ff, 11'h7ff));
  endtask

  task automatic test_transfers();
    // The first block ends exactly at the card size, which is still in range.
    send_item(cmd_item(IDX_READ_MULTI, 32'h003f_fe00));
    send_item(xfer_item(KIND_READ, 11'd1024, 11'd1024));
    send_item(cmd_item(IDX_SET_BLOCK_COUNT, 32'hffff_ffff));
    send_item(xfer_item(KIND_READ, 11'd3, 11'd512));
    send_item(cmd_item(IDX_WRITE_SINGLE, 32'hffff_ffff));
    send_item(xfer_item(KIND_WRITE, 11'h7ff, 11'h7ff));
    send_item(xfer_item(KIND_READ, 11'd1, 11'd1));
    send_item(cmd_item(IDX_APP_CMD, 32'h0));
    send_item(cmd_item(IDX_SEND_SCR, 32'h0));
    send_item(xfer_item(KIND_READ, 11'd0, 11'd0));
  endtask

  task automatic send_random_burst();
    in_item_t   it;
    logic [5:0] pick;
    int         n;
    case ($urandom_range(9))
      0, 1: begin
        if ($urandom_range(3) == 0)
          send_item(cmd_item(IDX_SET_BLOCKLEN, $urandom_range(512)));
        send_item(cmd_item($urandom_range(1) ? IDX_READ_SINGLE : IDX_READ_MULTI,
                           rand_address()));
        n = $urandom_range(4, 1);
        repeat (n) send_item(xfer_item(KIND_READ, rand_count(), rand_count()));
      end
      2, 3: begin
        send_item(cmd_item($urandom_range(1) ? IDX_WRITE_SINGLE : IDX_WRITE_MULTI,
                           rand_address()));
        n = $urandom_range(4, 1);
        repeat (n) send_item(xfer_item(KIND_WRITE, rand_count(), rand_count()));
        if ($urandom_range(4) == 0)
          send_item(xfer_item(KIND_READ, rand_count(), rand_count()));
      end
      4: begin
        send_item(cmd_item(IDX_APP_CMD, $urandom));
        case ($urandom_range(4))
          0: pick = IDX_SWITCH;
          1: pick = IDX_APP_OP_COND;
          2: pick = IDX_SEND_STATUS;
          3: pick = IDX_SEND_SCR;
          default: pick = 6'($urandom_range(63));
        endcase
        send_item(cmd_item(pick, $urandom));
        n = $urandom_range(3);
        repeat (n) send_item(xfer_item(KIND_READ, rand_count(), rand_count()));
      end
      5: begin
        send_item(cmd_item(IDX_GO_IDLE, $urandom));
        send_item(cmd_item(IDX_SEND_IF_COND, $urandom));
        send_item(cmd_item(IDX_APP_CMD, $urandom));
        send_item(cmd_item(IDX_APP_OP_COND, $urandom));
        send_item(cmd_item(IDX_ALL_SEND_CID, $urandom));
        send_item(cmd_item(IDX_SEND_RCA, $urandom));
        send_item(cmd_item(IDX_SEND_CSD, $urandom));
        send_item(cmd_item(IDX_SELECT, $urandom));
      end
      6: send_item(cmd_item(IDX_SET_BLOCKLEN,
                            $urandom_range(3) == 0 ? $urandom : $urandom_range(512)));
      7: send_item(cmd_item(legal_index[$urandom_range(21)], $urandom));
      default: begin
        it.command      = 2'($urandom_range(3));
        it.cmd_index    = 6'($urandom);
        it.cmd_argument = $urandom;
        it.block_count  = rand_count();
        it.block_size   = rand_count();
        send_item(it);
      end
    endcase
  endtask

  task automatic test_random_traffic(int send_pct, int recv_pct, int count);
    int target;
    configure_card({$urandom, $urandom}, {$urandom, $urandom},
                   {$urandom, $urandom}, {$urandom, $urandom});
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    target = items_sent + count;
    while (items_sent < target) send_random_burst();
  endtask

  initial begin
    rst_n                = 1'b0;
    in_chan.valid        = 1'b0;
    in_chan.command      = KIND_CMD;
    in_chan.cmd_index    = '0;
    in_chan.cmd_argument = '0;
    in_chan.block_count  = '0;
    in_chan.block_size   = '0;
    cfg_chan.valid       = 1'b0;
    cfg_chan.reg_index   = REG_CID_HIGH;
    cfg_chan.wr_data     = '0;
    send_idle_pct        = 32;
    recv_idle_pct        = 46;
    items_sent           = 0;
    results_seen         = 0;
    fail_count           = 0;
    crd_state            = ST_IDLE;
    model_status         = STATUS_RESET;
    card_rca             = '0;
    if_echo              = '0;
    app_armed            = 1'b0;
    prev_index           = '0;
    blk_len              = '0;
    xfer_ofs             = '0;
    model_regs           = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    test_card_registers();
    test_command_set();
    test_transfers();
    test_random_traffic(32, 46, 650);
    test_random_traffic(46, 32, 650);
    test_random_traffic(0, 0, 650);

    settle_block();
    if (fail_count == 0) begin
      $display("sd_card_command_state_machine_core test passed");
    end else begin
      $display("sd_card_command_state_machine_core test failed");
    end
    $finish;
  end

endmodule
